// ===== hdl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, command codes and helper functions of the SPI save memory
// command sequencer.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Program chunk sizes per device type, in bytes.
  localparam int TYPE1_CHUNK = 16;
  localparam int TYPE2_CHUNK = 32;
  localparam int TYPE3_CHUNK = 256;

  // Depth of the job queue between the front and the back end.
  localparam int JOB_FIFO_DEPTH = 4;
  localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);
  localparam int JOB_CNT_W      = $clog2(JOB_FIFO_DEPTH + 1);

  // Serial memory command bytes.
  localparam logic [7:0] CMD_READ        = 8'h03;
  localparam logic [7:0] CMD_PROGRAM     = 8'h02;
  localparam logic [7:0] CMD_WRITE_EN    = 8'h06;
  localparam logic [7:0] CMD_READ_STATUS = 8'h05;
  localparam logic [7:0] CMD_SECTOR_ERASE = 8'hD8;
  localparam logic [7:0] DUMMY_BYTE      = 8'h00;
  localparam int         STATUS_WIP_BIT  = 0;

  // Segments of a job, sent in this order.
  localparam int SEG_WREN       = 0;
  localparam int SEG_CMD        = 1;
  localparam int SEG_ADDR       = 2;
  localparam int SEG_BODY       = 3;
  localparam int SEG_POLL_CMD   = 4;
  localparam int SEG_POLL_DUMMY = 5;
  localparam int SEG_COUNT      = 6;

  // Device types as written to the configuration register.
  localparam logic [1:0] DEV_SMALL_EEPROM  = 2'd1;
  localparam logic [1:0] DEV_MEDIUM_EEPROM = 2'd2;
  localparam logic [1:0] DEV_FLASH         = 2'd3;

  // Configuration register index.
  localparam logic REG_DEVICE_TYPE = 1'b0;

  typedef enum logic [1:0] {
    FN_READ     = 2'd0,
    FN_WRITE    = 2'd1,
    FN_ERASE    = 2'd2,
    FN_RESPONSE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_READ_OPEN     = 3'd1,
    PH_READ_WAIT     = 3'd2,
    PH_WRITE_BETWEEN = 3'd3,
    PH_WRITE_CHUNK   = 3'd4,
    PH_POLL          = 3'd5
  } phase_e;

  // One classified item, expanded into beats by the back end.
  typedef struct packed {
    logic [SEG_COUNT-1:0] mask;
    logic [7:0]           cmd;
    logic [23:0]          addr;
    logic [1:0]           addr_len;
    logic                 addr_rel;
    logic                 body_send;
    logic                 body_rel;
    logic                 body_rv;
    logic                 body_done;
    logic [7:0]           body_byte;
  } job_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       send_valid;
    logic       release_select;
    logic       read_valid;
    logic [7:0] read_data;
    logic       op_done;
    logic       run_last;
  } beat_t;

  // Unknown device types behave as flash.
  function automatic logic [1:0] eff_type(input logic [1:0] dev);
    logic [1:0] t;
    t = (dev == DEV_SMALL_EEPROM || dev == DEV_MEDIUM_EEPROM) ? dev : DEV_FLASH;
    return t;
  endfunction

  function automatic logic [8:0] chunk_limit(input logic [1:0] t);
    logic [8:0] lim;
    unique case (t)
      DEV_SMALL_EEPROM:  lim = 9'(TYPE1_CHUNK);
      DEV_MEDIUM_EEPROM: lim = 9'(TYPE2_CHUNK);
      default:           lim = 9'(TYPE3_CHUNK);
    endcase
    return lim;
  endfunction

  // Small EEPROMs carry address bit 8 in bit 3 of the command byte.
  function automatic logic [7:0] cmd_with_bit8(input logic [7:0] cmd,
                                               input logic [23:0] addr,
                                               input logic [1:0] t);
    logic [7:0] c;
    c = cmd;
    if (t == DEV_SMALL_EEPROM) begin
      c[3] = c[3] | addr[8];
    end
    return c;
  endfunction

endpackage

// ===== hdl/spi_save_memory_command_sequencer.sv =====
// Path: an accepted item is registered in the job queue, then in the back end's
// job register, and its first result beat is registered in the output register.
// Throughput: one result beat per cycle while the output is taken; an item causes
// up to eight results. A four-entry job queue lets input beats be taken while
// earlier jobs are still being expanded.
// Reset: asynchronous, active low; device type returns to flash, phase to idle.
// ----------------------------------------------------------------------------
// spi_save_memory_command_sequencer
// Host-side command sequencer for SPI serial EEPROM and flash save memory:
// read, program and sector erase items in, SPI byte beats out.
// ----------------------------------------------------------------------------
module spi_save_memory_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // address[23:0], data_byte[31:24], first[32]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  input  logic        s_axis_tlast,  // final_byte
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // mosi_byte[7:0], send_valid[8],
                                     // release_select[9], read_valid[10],
                                     // read_data[18:11], op_done[19]
  output logic        m_axis_tlast   // run_last
);

  logic [1:0]     device_type_q;
  logic           push;
  logic           push_ready;
  ssm_pkg::job_t  push_job;
  logic           pop;
  logic           pop_valid;
  ssm_pkg::job_t  pop_job;
  ssm_pkg::beat_t out_beat;

  // Device type register.
  assign pready = 1'b1;
  assign prdata = {30'd0, device_type_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_type_q <= ssm_pkg::DEV_FLASH;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == ssm_pkg::REG_DEVICE_TYPE)) begin
      device_type_q <= pwdata[1:0];
    end
  end

  // Front end: classify items into jobs.
  ssm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .device_type_i (device_type_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .func_i        (s_axis_tuser),
    .address_i     (s_axis_tdata[23:0]),
    .data_byte_i   (s_axis_tdata[31:24]),
    .final_byte_i  (s_axis_tlast),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .job_o         (push_job)
  );

  // Job queue.
  ssm_job_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job)
  );

  // Back end: expand jobs into beats.
  ssm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (out_beat)
  );

  // Result beat packing.
  assign m_axis_tdata = {4'd0, out_beat.op_done, out_beat.read_data, out_beat.read_valid,
                         out_beat.release_select, out_beat.send_valid, out_beat.mosi_byte};
  assign m_axis_tlast = out_beat.run_last;

endmodule

// ===== hdl/ssm_front.sv =====
// ----------------------------------------------------------------------------
// ssm_front
// Accepts input beats, tracks the transfer phase and turns each item into a
// job descriptor for the back end. Items that do not fit the phase are dropped.
// ----------------------------------------------------------------------------
module ssm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         device_type_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [23:0]        address_i,
  input  logic [7:0]         data_byte_i,
  input  logic               final_byte_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output ssm_pkg::job_t      job_o
);

  ssm_pkg::phase_e phase_q, phase_d;
  logic [8:0]      chunk_count_q, chunk_count_d;
  logic [23:0]     next_address_q, next_address_d;
  logic            transfer_continues_q, transfer_continues_d;
  logic            read_ending_q, read_ending_d;

  logic [1:0]      eff_t;
  logic            accept;
  logic            keep;
  logic            wr_opening;
  logic [23:0]     wr_base;
  logic [8:0]      wr_count;
  logic            wr_closing;

  assign eff_t      = ssm_pkg::eff_type(device_type_i);
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept && keep;

  // Write chunk bookkeeping: a chunk opens from idle or between chunks.
  assign wr_opening = (phase_q == ssm_pkg::PH_IDLE) ||
                      (phase_q == ssm_pkg::PH_WRITE_BETWEEN);
  assign wr_base    = (phase_q == ssm_pkg::PH_IDLE) ? address_i : next_address_q;
  assign wr_count   = (wr_opening ? 9'd0 : chunk_count_q) + 9'd1;
  assign wr_closing = (wr_count >= ssm_pkg::chunk_limit(eff_t)) || final_byte_i;

  // Classify the item and build its job.
  always_comb begin
    job_o                = '0;
    keep                 = 1'b0;
    phase_d              = phase_q;
    chunk_count_d        = chunk_count_q;
    next_address_d       = next_address_q;
    transfer_continues_d = transfer_continues_q;
    read_ending_d        = read_ending_q;
    unique case (ssm_pkg::func_e'(func_i))
      ssm_pkg::FN_READ: begin
        if (phase_q == ssm_pkg::PH_IDLE || phase_q == ssm_pkg::PH_READ_OPEN) begin
          keep = 1'b1;
          if (phase_q == ssm_pkg::PH_IDLE) begin
            job_o.mask[ssm_pkg::SEG_CMD]  = 1'b1;
            job_o.mask[ssm_pkg::SEG_ADDR] = 1'b1;
            job_o.cmd      = ssm_pkg::cmd_with_bit8(ssm_pkg::CMD_READ, address_i, eff_t);
            job_o.addr     = address_i;
            job_o.addr_len = eff_t;
          end
          job_o.mask[ssm_pkg::SEG_BODY] = 1'b1;
          job_o.body_send = 1'b1;
          job_o.body_byte = ssm_pkg::DUMMY_BYTE;
          read_ending_d   = final_byte_i;
          phase_d         = ssm_pkg::PH_READ_WAIT;
        end
      end
      ssm_pkg::FN_WRITE: begin
        if (wr_opening || phase_q == ssm_pkg::PH_WRITE_CHUNK) begin
          keep = 1'b1;
          if (wr_opening) begin
            job_o.mask[ssm_pkg::SEG_WREN] = 1'b1;
            job_o.mask[ssm_pkg::SEG_CMD]  = 1'b1;
            job_o.mask[ssm_pkg::SEG_ADDR] = 1'b1;
            job_o.cmd      = ssm_pkg::cmd_with_bit8(ssm_pkg::CMD_PROGRAM, wr_base, eff_t);
            job_o.addr     = wr_base;
            job_o.addr_len = eff_t;
          end
          job_o.mask[ssm_pkg::SEG_BODY] = 1'b1;
          job_o.body_send = 1'b1;
          job_o.body_rel  = wr_closing;
          job_o.body_byte = data_byte_i;
          next_address_d  = wr_base + 24'd1;
          if (wr_closing) begin
            job_o.mask[ssm_pkg::SEG_POLL_CMD]   = 1'b1;
            job_o.mask[ssm_pkg::SEG_POLL_DUMMY] = 1'b1;
            chunk_count_d        = 9'd0;
            transfer_continues_d = !final_byte_i;
            phase_d              = ssm_pkg::PH_POLL;
          end else begin
            chunk_count_d = wr_count;
            phase_d       = ssm_pkg::PH_WRITE_CHUNK;
          end
        end
      end
      ssm_pkg::FN_ERASE: begin
        if (phase_q == ssm_pkg::PH_IDLE) begin
          keep = 1'b1;
          job_o.mask[ssm_pkg::SEG_WREN]       = 1'b1;
          job_o.mask[ssm_pkg::SEG_CMD]        = 1'b1;
          job_o.mask[ssm_pkg::SEG_ADDR]       = 1'b1;
          job_o.mask[ssm_pkg::SEG_POLL_CMD]   = 1'b1;
          job_o.mask[ssm_pkg::SEG_POLL_DUMMY] = 1'b1;
          job_o.cmd            = ssm_pkg::CMD_SECTOR_ERASE;
          job_o.addr           = address_i;
          job_o.addr_len       = 2'd3;
          job_o.addr_rel       = 1'b1;
          transfer_continues_d = 1'b0;
          phase_d              = ssm_pkg::PH_POLL;
        end
      end
      ssm_pkg::FN_RESPONSE: begin
        if (phase_q == ssm_pkg::PH_READ_WAIT) begin
          keep = 1'b1;
          job_o.mask[ssm_pkg::SEG_BODY] = 1'b1;
          job_o.body_rel  = read_ending_q;
          job_o.body_rv   = 1'b1;
          job_o.body_byte = data_byte_i;
          phase_d         = read_ending_q ? ssm_pkg::PH_IDLE : ssm_pkg::PH_READ_OPEN;
          read_ending_d   = 1'b0;
        end else if (phase_q == ssm_pkg::PH_POLL) begin
          keep = 1'b1;
          job_o.mask[ssm_pkg::SEG_BODY] = 1'b1;
          if (data_byte_i[ssm_pkg::STATUS_WIP_BIT]) begin
            // Still busy: clock out one more status byte.
            job_o.body_send = 1'b1;
            job_o.body_byte = ssm_pkg::DUMMY_BYTE;
          end else begin
            job_o.body_rel       = 1'b1;
            job_o.body_done      = 1'b1;
            phase_d              = transfer_continues_q ? ssm_pkg::PH_WRITE_BETWEEN
                                                        : ssm_pkg::PH_IDLE;
            transfer_continues_d = 1'b0;
          end
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Phase and transfer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q              <= ssm_pkg::PH_IDLE;
      chunk_count_q        <= '0;
      next_address_q       <= '0;
      transfer_continues_q <= 1'b0;
      read_ending_q        <= 1'b0;
    end else if (accept) begin
      phase_q              <= phase_d;
      chunk_count_q        <= chunk_count_d;
      next_address_q       <= next_address_d;
      transfer_continues_q <= transfer_continues_d;
      read_ending_q        <= read_ending_d;
    end
  end

  // A chunk count never survives into the polling phase.
  a_poll_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ssm_pkg::PH_POLL) |-> (chunk_count_q == 9'd0))
    else $error("chunk count not cleared while polling");

endmodule

// ===== hdl/ssm_job_fifo.sv =====
// ----------------------------------------------------------------------------
// ssm_job_fifo
// Short job queue that decouples item classification from beat generation.
// ----------------------------------------------------------------------------
module ssm_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  ssm_pkg::job_t push_job_i,
  input  logic          pop_i,
  output logic          pop_valid_o,
  output ssm_pkg::job_t pop_job_o
);

  ssm_pkg::job_t                      entries_q [ssm_pkg::JOB_FIFO_DEPTH];
  logic [ssm_pkg::JOB_PTR_W-1:0]      head_q, tail_q;
  logic [ssm_pkg::JOB_CNT_W-1:0]      count_q;

  assign push_ready_o = (count_q != ssm_pkg::JOB_CNT_W'(ssm_pkg::JOB_FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = entries_q[head_q];

  // Storage written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[tail_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        tail_q <= tail_q + 1'b1;
      end
      if (pop_i) begin
        head_q <= head_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // A job must never be pushed into a full queue or popped from an empty one.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> push_ready_o) and (pop_i |-> pop_valid_o))
    else $error("job queue overflow or underflow");

endmodule

// ===== hdl/ssm_back.sv =====
// ----------------------------------------------------------------------------
// ssm_back
// Expands queued jobs into result beats, one beat per cycle, into an output
// register; the sequencer holds while the previous beat waits to be taken.
// ----------------------------------------------------------------------------
module ssm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  ssm_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssm_pkg::beat_t out_beat_o
);

  ssm_pkg::job_t                  job_q;
  logic                           busy_q;
  logic [ssm_pkg::SEG_COUNT-1:0]  mask_q, mask_next;
  logic [1:0]                     addr_left_q;
  logic                           out_valid_q;
  ssm_pkg::beat_t                 out_beat_q;

  ssm_pkg::beat_t                 beat;
  logic                           emit;
  logic                           last;
  logic                           in_addr;
  logic [7:0]                     addr_byte;

  assign emit      = busy_q && (!out_valid_q || out_ready_i);
  assign in_addr   = (mask_q[ssm_pkg::SEG_ADDR] && (mask_q[ssm_pkg::SEG_CMD:0] == '0));
  assign job_pop_o = job_valid_i && (!busy_q || (emit && last));

  // Address bytes go out most significant first.
  always_comb begin
    unique case (addr_left_q)
      2'd3:    addr_byte = job_q.addr[23:16];
      2'd2:    addr_byte = job_q.addr[15:8];
      default: addr_byte = job_q.addr[7:0];
    endcase
  end

  // Remaining segments after this beat; the address segment stays until its
  // last byte has gone.
  always_comb begin
    if (in_addr && addr_left_q > 2'd1) begin
      mask_next = mask_q;
    end else begin
      mask_next = mask_q & (mask_q - 1'b1);
    end
  end
  assign last = (mask_next == '0);

  // Beat of the current segment.
  always_comb begin
    beat = '0;
    priority if (mask_q[ssm_pkg::SEG_WREN]) begin
      beat.mosi_byte      = ssm_pkg::CMD_WRITE_EN;
      beat.send_valid     = 1'b1;
      beat.release_select = 1'b1;
    end else if (mask_q[ssm_pkg::SEG_CMD]) begin
      beat.mosi_byte  = job_q.cmd;
      beat.send_valid = 1'b1;
    end else if (mask_q[ssm_pkg::SEG_ADDR]) begin
      beat.mosi_byte      = addr_byte;
      beat.send_valid     = 1'b1;
      beat.release_select = job_q.addr_rel && (addr_left_q == 2'd1);
    end else if (mask_q[ssm_pkg::SEG_BODY]) begin
      beat.mosi_byte      = job_q.body_send ? job_q.body_byte : 8'h00;
      beat.send_valid     = job_q.body_send;
      beat.release_select = job_q.body_rel;
      beat.read_valid     = job_q.body_rv;
      beat.read_data      = job_q.body_rv ? job_q.body_byte : 8'h00;
      beat.op_done        = job_q.body_done;
    end else if (mask_q[ssm_pkg::SEG_POLL_CMD]) begin
      beat.mosi_byte  = ssm_pkg::CMD_READ_STATUS;
      beat.send_valid = 1'b1;
    end else begin
      beat.mosi_byte  = ssm_pkg::DUMMY_BYTE;
      beat.send_valid = 1'b1;
    end
    beat.run_last = last;
  end

  // Job sequencing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      addr_left_q <= '0;
    end else if (job_pop_o) begin
      busy_q      <= 1'b1;
      mask_q      <= job_i.mask;
      addr_left_q <= job_i.addr_len;
    end else if (emit) begin
      busy_q <= !last;
      mask_q <= mask_next;
      if (in_addr) begin
        addr_left_q <= addr_left_q - 2'd1;
      end
    end
  end

  // Job payload.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_beat_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // A busy sequencer always has a segment left to send.
  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (mask_q != '0))
    else $error("sequencer busy with an empty job");

  // Read data beats never drive the bus.
  a_read_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && beat.read_valid) |-> !beat.send_valid)
    else $error("read data beat marked for transmission");

endmodule

// ===== verif/tb_spi_save_memory_command_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_save_memory_command_sequencer
// Self-checking bench for the SPI save memory command sequencer. Read,
// program, erase and response beats go in on the input stream. An in-bench
// predictor expands each accepted beat into the SPI byte beats it should
// cause, and every result beat is compared field by field in order. Device
// types are switched over the APB port between phases, and mid-transfer too.
// ----------------------------------------------------------------------------
module tb_spi_save_memory_command_sequencer;

  localparam int RANDOM_BEATS     = 30;
  localparam int LONG_RUN_BYTES   = 257;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 16;
  localparam int QUIET_LIMIT      = 2000;

  // Type 0 is not a real chip and must behave as flash.
  localparam logic [1:0] DEV_UNSET     = 2'd0;
  localparam logic [2:0] DEV_TYPE_ADDR = 3'(ssm_pkg::REG_DEVICE_TYPE) << 2;

  typedef struct packed {
    ssm_pkg::func_e func;
    logic [23:0]    address;
    logic [7:0]     data_byte;
    logic           first;
    logic           final_byte;
  } save_req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Stimulus bookkeeping.
  save_req_t       pending_reqs[$];
  ssm_pkg::beat_t  spi_beats_due[$];
  int          reqs_queued   = 0;
  int          reqs_taken    = 0;
  int          beats_checked = 0;
  int          mismatches    = 0;
  int          quiet_cycles  = 0;
  int          in_gap        = 0;
  int          out_gap       = 0;
  bit          in_taken      = 1'b0;
  bit          gaps_on       = 1'b1;
  bit          long_hold_go  = 1'b0;
  bit          long_hold_started = 1'b0;
  logic [1:0]  cur_type      = ssm_pkg::DEV_FLASH;

  // Predictor state.
  logic [1:0]       dev_type      = ssm_pkg::DEV_FLASH;
  ssm_pkg::phase_e  seq_phase     = ssm_pkg::PH_IDLE;
  logic [8:0]  chunk_fill    = '0;
  logic [23:0] prog_addr     = '0;
  logic        more_chunks   = 1'b0;
  logic        read_closing  = 1'b0;

  always #5 clk_i = ~clk_i;

  spi_save_memory_command_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [1:0] chip_kind(input logic [1:0] t);
    if (t == ssm_pkg::DEV_SMALL_EEPROM || t == ssm_pkg::DEV_MEDIUM_EEPROM) begin
      return t;
    end
    return ssm_pkg::DEV_FLASH;
  endfunction

  function automatic logic [8:0] chunk_bytes(input logic [1:0] t);
    case (chip_kind(t))
      ssm_pkg::DEV_SMALL_EEPROM:  return 9'(ssm_pkg::TYPE1_CHUNK);
      ssm_pkg::DEV_MEDIUM_EEPROM: return 9'(ssm_pkg::TYPE2_CHUNK);
      default:                    return 9'(ssm_pkg::TYPE3_CHUNK);
    endcase
  endfunction

  // Small EEPROMs carry address bit 8 inside the command byte.
  function automatic logic [7:0] fold_bit8(input logic [7:0] cmd, input logic [23:0] a);
    logic [7:0] c;
    c = cmd;
    if (chip_kind(dev_type) == ssm_pkg::DEV_SMALL_EEPROM) begin
      c[3] = c[3] | a[8];
    end
    return c;
  endfunction

  task automatic queue_beat(input logic [7:0] mosi, input logic snd, input logic rel,
                            input logic rv, input logic [7:0] rd, input logic done);
    ssm_pkg::beat_t b;
    b.mosi_byte      = snd ? mosi : 8'h00;
    b.send_valid     = snd;
    b.release_select = rel;
    b.read_valid     = rv;
    b.read_data      = rv ? rd : 8'h00;
    b.op_done        = done;
    b.run_last       = 1'b0;
    spi_beats_due.push_back(b);
  endtask

  // Address bytes go out most significant first.
  task automatic queue_addr(input logic [23:0] a, input int nbytes, input logic rel_last);
    for (int i = nbytes; i > 0; i--) begin
      queue_beat(8'(a >> (8 * (i - 1))), 1'b1, (i == 1) ? rel_last : 1'b0, 1'b0, 8'h00, 1'b0);
    end
  endtask

  // Expands one accepted request into the SPI beats it causes.
  task automatic expand_request(input save_req_t r);
    int   mark;
    logic closing;
    mark = spi_beats_due.size();
    case (r.func)
      ssm_pkg::FN_READ: begin
        if (seq_phase == ssm_pkg::PH_IDLE) begin
          queue_beat(fold_bit8(ssm_pkg::CMD_READ, r.address), 1'b1, 1'b0, 1'b0, 8'h00,
                     1'b0);
          queue_addr(r.address, int'(chip_kind(dev_type)), 1'b0);
        end
        if (seq_phase == ssm_pkg::PH_IDLE || seq_phase == ssm_pkg::PH_READ_OPEN) begin
          queue_beat(ssm_pkg::DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
          read_closing = r.final_byte;
          seq_phase    = ssm_pkg::PH_READ_WAIT;
        end
      end
      ssm_pkg::FN_WRITE: begin
        if (seq_phase == ssm_pkg::PH_IDLE) begin
          prog_addr  = r.address;
          chunk_fill = '0;
          seq_phase  = ssm_pkg::PH_WRITE_BETWEEN;
        end
        // A new chunk: write enable with deselect, then program and address.
        if (seq_phase == ssm_pkg::PH_WRITE_BETWEEN) begin
          queue_beat(ssm_pkg::CMD_WRITE_EN, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
          queue_beat(fold_bit8(ssm_pkg::CMD_PROGRAM, prog_addr), 1'b1, 1'b0, 1'b0, 8'h00,
                     1'b0);
          queue_addr(prog_addr, int'(chip_kind(dev_type)), 1'b0);
          chunk_fill = '0;
          seq_phase  = ssm_pkg::PH_WRITE_CHUNK;
        end
        if (seq_phase == ssm_pkg::PH_WRITE_CHUNK) begin
          chunk_fill = chunk_fill + 9'd1;
          prog_addr  = prog_addr + 24'd1;
          closing    = (chunk_fill >= chunk_bytes(dev_type)) || r.final_byte;
          queue_beat(r.data_byte, 1'b1, closing, 1'b0, 8'h00, 1'b0);
          if (closing) begin
            queue_beat(ssm_pkg::CMD_READ_STATUS, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            queue_beat(ssm_pkg::DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            chunk_fill  = '0;
            more_chunks = !r.final_byte;
            seq_phase   = ssm_pkg::PH_POLL;
          end
        end
      end
      ssm_pkg::FN_ERASE: begin
        if (seq_phase == ssm_pkg::PH_IDLE) begin
          queue_beat(ssm_pkg::CMD_WRITE_EN, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
          queue_beat(ssm_pkg::CMD_SECTOR_ERASE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
          queue_addr(r.address, 3, 1'b1);
          queue_beat(ssm_pkg::CMD_READ_STATUS, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
          queue_beat(ssm_pkg::DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
          more_chunks = 1'b0;
          seq_phase   = ssm_pkg::PH_POLL;
        end
      end
      default: begin
        if (seq_phase == ssm_pkg::PH_READ_WAIT) begin
          queue_beat(8'h00, 1'b0, read_closing, 1'b1, r.data_byte, 1'b0);
          seq_phase    = read_closing ? ssm_pkg::PH_IDLE : ssm_pkg::PH_READ_OPEN;
          read_closing = 1'b0;
        end else if (seq_phase == ssm_pkg::PH_POLL) begin
          // Keep polling while the write-in-progress bit is set.
          if (r.data_byte[ssm_pkg::STATUS_WIP_BIT]) begin
            queue_beat(ssm_pkg::DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
          end else begin
            queue_beat(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
            seq_phase   = more_chunks ? ssm_pkg::PH_WRITE_BETWEEN : ssm_pkg::PH_IDLE;
            more_chunks = 1'b0;
          end
        end
      end
    endcase
    if (spi_beats_due.size() > mark) begin
      spi_beats_due[spi_beats_due.size() - 1].run_last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input beats, checks result beats, tracks the register.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    save_req_t      r;
    ssm_pkg::beat_t got;
    ssm_pkg::beat_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (psel && penable && pwrite && pready && paddr == DEV_TYPE_ADDR) begin
        dev_type = pwdata[1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        r.func       = ssm_pkg::func_e'(s_axis_tuser);
        r.address    = s_axis_tdata[23:0];
        r.data_byte  = s_axis_tdata[31:24];
        r.first      = s_axis_tdata[32];
        r.final_byte = s_axis_tlast;
        expand_request(r);
        reqs_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9], m_axis_tdata[10],
               m_axis_tdata[18:11], m_axis_tdata[19], m_axis_tlast};
        beats_checked++;
        if (spi_beats_due.size() == 0) begin
          report_mismatch("result beat with none expected", 32'(got), 32'd0);
        end else begin
          want = spi_beats_due.pop_front();
          if (got.mosi_byte !== want.mosi_byte)
            report_mismatch("mosi_byte", 32'(got.mosi_byte), 32'(want.mosi_byte));
          if (got.send_valid !== want.send_valid)
            report_mismatch("send_valid", 32'(got.send_valid), 32'(want.send_valid));
          if (got.release_select !== want.release_select)
            report_mismatch("release_select", 32'(got.release_select),
                            32'(want.release_select));
          if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", 32'(got.read_valid), 32'(want.read_valid));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
          if (got.op_done !== want.op_done)
            report_mismatch("op_done", 32'(got.op_done), 32'(want.op_done));
          if (got.run_last !== want.run_last)
            report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
        end
      end
    end
  end

  // Input driver: holds a beat until it is taken, with random gaps between beats.
  always @(negedge clk_i) begin : drive_in
    save_req_t r;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 4);
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        s_axis_tdata  <= {7'd0, r.first, r.data_byte, r.address};
        s_axis_tuser  <= r.func;
        s_axis_tlast  <= r.final_byte;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus one long hold to back the block up.
  always @(negedge clk_i) begin : drive_out
    if (rst_ni) begin
      if (long_hold_go && !long_hold_started) begin
        long_hold_started = 1'b1;
        out_gap = LONG_HOLD_CYCLES;
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d result beats outstanding",
               quiet_cycles, spi_beats_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // Favors the top of the address space and the bit 8 region of small parts.
  function automatic logic [23:0] rand_addr();
    case ($urandom_range(0, 3))
      0:       return 24'hFFFFF0 + 24'($urandom_range(0, 15));
      1:       return 24'($urandom_range(0, 511));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic push_req(input ssm_pkg::func_e f, input logic [23:0] a, input logic [7:0] d,
                          input logic fst, input logic fin);
    save_req_t r;
    r.func       = f;
    r.address    = a;
    r.data_byte  = d;
    r.first      = fst;
    r.final_byte = fin;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic drain();
    while (reqs_taken != reqs_queued || spi_beats_due.size() != 0) @(posedge clk_i);
  endtask

  // Quiet point for register writes: everything answered, then a wait of SETTLE_CYCLES.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write followed by a read-back.
  task automatic write_device_type(input logic [1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DEV_TYPE_ADDR;
    pwdata  <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(v)) report_mismatch("device_type read-back", prdata, 32'(v));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_type = v;
  endtask

  // Status polls: up to three busy answers, then write-in-progress clear.
  task automatic push_status_polls();
    int busy;
    busy = $urandom_range(0, 3);
    repeat (busy) begin
      push_req(ssm_pkg::FN_RESPONSE, rand_addr(), rand_byte() | 8'h01, coin(), coin());
    end
    push_req(ssm_pkg::FN_RESPONSE, rand_addr(), rand_byte() & 8'hFE, coin(), coin());
  endtask

  // Program run with polls after each chunk; may switch the type part way.
  task automatic push_write_run(input int len, input bit allow_split);
    int   fill;
    int   split_at;
    logic fin;
    fill     = 0;
    split_at = (allow_split && $urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      fin = (i == len - 1);
      push_req(ssm_pkg::FN_WRITE, rand_addr(), rand_byte(), (i == 0) ? 1'b1 : coin(),
               fin);
      fill++;
      if (fill >= int'(chunk_bytes(cur_type)) || fin) begin
        push_status_polls();
        fill = 0;
      end else if (i == split_at) begin
        settle();
        write_device_type(2'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic push_read_run(input int len);
    for (int i = 0; i < len; i++) begin
      push_req(ssm_pkg::FN_READ, rand_addr(), rand_byte(), (i == 0) ? 1'b1 : coin(),
               i == len - 1);
      push_req(ssm_pkg::FN_RESPONSE, rand_addr(), rand_byte(), coin(), coin());
    end
  endtask

  // Brings the block back to idle after noise, one beat at a time.
  task automatic recover();
    drain();
    while (seq_phase != ssm_pkg::PH_IDLE) begin
      case (seq_phase)
        ssm_pkg::PH_READ_OPEN:
          push_req(ssm_pkg::FN_READ, rand_addr(), rand_byte(), coin(), 1'b1);
        ssm_pkg::PH_WRITE_BETWEEN, ssm_pkg::PH_WRITE_CHUNK:
          push_req(ssm_pkg::FN_WRITE, rand_addr(), rand_byte(), coin(), 1'b1);
        ssm_pkg::PH_POLL:
          push_req(ssm_pkg::FN_RESPONSE, rand_addr(), rand_byte() & 8'hFE, coin(), coin());
        default:
          push_req(ssm_pkg::FN_RESPONSE, rand_addr(), rand_byte(), coin(), coin());
      endcase
      drain();
    end
  endtask

  initial begin : stimulus
    int random_base;
    int noise_total;
    int noise_mark;
    int kind;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Flash after reset: read at the top address, stray beats in an open read,
    // a first flag inside the transfer, and a response while idle.
    push_req(ssm_pkg::FN_READ, 24'hFFFFFF, 8'h00, 1'b1, 1'b0);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'hFF, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_WRITE, 24'h000000, 8'h55, 1'b1, 1'b1);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h00, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_READ, 24'h000000, 8'hFF, 1'b1, 1'b1);
    push_req(ssm_pkg::FN_RESPONSE, 24'hFFFFFF, 8'hA5, 1'b1, 1'b1);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h00, 1'b0, 1'b0);
    // Sector erase, a read while polling, one busy status, then clear.
    push_req(ssm_pkg::FN_ERASE, 24'h000000, 8'hFF, 1'b1, 1'b1);
    push_req(ssm_pkg::FN_READ, 24'h123456, 8'h00, 1'b1, 1'b1);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h01, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'hFE, 1'b0, 1'b0);
    settle();

    // Small EEPROM: transfers opened without the first flag, address bit 8
    // folded into the command, and an erase inside an open write.
    write_device_type(ssm_pkg::DEV_SMALL_EEPROM);
    push_req(ssm_pkg::FN_WRITE, 24'h0001FF, 8'h00, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_ERASE, 24'h000000, 8'h00, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_WRITE, 24'h000000, 8'hFF, 1'b0, 1'b1);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h00, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_READ, 24'h0001A5, 8'h00, 1'b0, 1'b1);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h3C, 1'b0, 1'b0);
    settle();

    // Medium EEPROM: one-byte program at the top address.
    write_device_type(ssm_pkg::DEV_MEDIUM_EEPROM);
    push_req(ssm_pkg::FN_WRITE, 24'hFFFFFF, 8'h80, 1'b1, 1'b1);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h03, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h00, 1'b0, 1'b0);
    settle();

    // Type zero falls back to flash addressing.
    write_device_type(DEV_UNSET);
    push_req(ssm_pkg::FN_READ, 24'h123456, 8'h00, 1'b1, 1'b1);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h81, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_ERASE, 24'hFFFFFF, 8'h00, 1'b0, 1'b0);
    push_req(ssm_pkg::FN_RESPONSE, 24'h000000, 8'h00, 1'b0, 1'b0);
    settle();

    // Long flash program that crosses a full 256-byte chunk while the output
    // side holds off, so the job queue fills and the input stalls.
    write_device_type(ssm_pkg::DEV_FLASH);
    long_hold_go = 1'b1;
    push_write_run(LONG_RUN_BYTES, 1'b0);
    drain();

    // Random part: mostly well-formed transfers, with noise and type changes.
    random_base = reqs_queued;
    noise_total = 0;
    while (reqs_queued - random_base - noise_total < RANDOM_BEATS) begin
      if (reqs_queued - random_base - noise_total > RANDOM_BEATS - 10) gaps_on = 1'b0;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: push_read_run($urandom_range(1, 6));
        6: begin
          push_req(ssm_pkg::FN_ERASE, rand_addr(), rand_byte(), coin(), coin());
          push_status_polls();
        end
        7: begin
          noise_mark = reqs_queued;
          repeat ($urandom_range(1, 4)) begin
            push_req(ssm_pkg::func_e'($urandom_range(0, 3)), rand_addr(), rand_byte(),
                     coin(), coin());
          end
          recover();
          noise_total += reqs_queued - noise_mark;
        end
        8: begin
          settle();
          write_device_type(2'($urandom_range(0, 3)));
        end
        default: begin
          if ($urandom_range(0, 3) == 0) push_write_run($urandom_range(17, 30), 1'b1);
          else push_write_run($urandom_range(1, 16), 1'b1);
        end
      endcase
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (spi_beats_due.size() != 0) begin
      report_mismatch("result beats never delivered", 32'(spi_beats_due.size()), 32'd0);
    end

    $display("Covered %0d input beats and %0d result beats over device types 0 to 3,",
             reqs_taken, beats_checked);
    $display("with stray beats, mid-transfer type changes and a long output stall.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
